/* rtl/core/bsoc_pkg.sv */
// ----------------------------------------------------------------------------
// Battery charge monitor package
// Field widths, register codes, reset values, shared types and the voltage
// to charge segment table used by the battery charge monitor.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  // Widths of the external fields and registers.
  localparam int unsigned MV_W       = 14;
  localparam int unsigned SOC_W      = 10;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned SLOPE_W    = 2;

  // Fixed voltages and charge limits.
  localparam int unsigned FULL_SCALE_MV = 9900;
  localparam int unsigned RESET_MV      = 7400;
  localparam int unsigned MV_EMPTY      = 6000;
  localparam int unsigned MV_FULL       = 8400;
  localparam int unsigned SOC_MAX       = 1000;

  // Register reset values.
  localparam int unsigned ALPHA_RESET = 26;
  localparam int unsigned LOW_RESET   = 200;
  localparam int unsigned CRIT_RESET  = 100;

  // Register indexes of the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_LOW   = 2'd1,
    CFG_CRIT  = 2'd2
  } cfg_idx_e;

  // Charge level codes.
  typedef enum logic [LEVEL_W-1:0] {
    LEVEL_NORMAL   = 2'd0,
    LEVEL_LOW      = 2'd1,
    LEVEL_CRITICAL = 2'd2
  } level_e;

  // Register bank handed to the datapath.
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [THR_W-1:0]   low_thr;
    logic [THR_W-1:0]   crit_thr;
  } cfg_t;

  // One finished result.
  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [SOC_W-1:0] soc;
    level_e           level;
    logic             stop;
  } result_t;

  // One linear segment: lower voltage bound, charge at that bound and the
  // slope in quarters of a tenth percent per millivolt.
  typedef struct packed {
    logic [MV_W-1:0]    lo;
    logic [SOC_W-1:0]   base;
    logic [SLOPE_W-1:0] k;
  } seg_t;

  // Segment lookup. A voltage exactly on a boundary uses the upper segment.
  function automatic seg_t seg_of(input logic [MV_W-1:0] mv);
    seg_t s;
    if (mv >= 14'd8000) begin
      s = '{lo: 14'd8000, base: 10'd900, k: 2'd1};
    end else if (mv >= 14'd7600) begin
      s = '{lo: 14'd7600, base: 10'd700, k: 2'd2};
    end else if (mv >= 14'd7200) begin
      s = '{lo: 14'd7200, base: 10'd400, k: 2'd3};
    end else if (mv >= 14'd6800) begin
      s = '{lo: 14'd6800, base: 10'd200, k: 2'd2};
    end else if (mv >= 14'd6400) begin
      s = '{lo: 14'd6400, base: 10'd100, k: 2'd1};
    end else begin
      s = '{lo: 14'd6000, base: 10'd0, k: 2'd1};
    end
    return s;
  endfunction

endpackage

/* rtl/core/bsoc_if.sv */
// ----------------------------------------------------------------------------
// Battery charge monitor channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------

// Sample channel: one converter reading and the motion flag per transfer.
interface bsoc_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic                   vehicle_moving;

  modport source (output valid, output adc_sample, output vehicle_moving, input ready);
  modport sink   (input valid, input adc_sample, input vehicle_moving, output ready);
endinterface

// Result channel: one gauge reading per transfer.
interface bsoc_out_if import bsoc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MV_W-1:0]    filtered_millivolts;
  logic [SOC_W-1:0]   charge_tenths;
  logic [LEVEL_W-1:0] charge_level;
  logic               stop_request;

  modport source (output valid, output filtered_millivolts, output charge_tenths,
                  output charge_level, output stop_request, input ready);
  modport sink   (input valid, input filtered_millivolts, input charge_tenths,
                  input charge_level, input stop_request, output ready);
endinterface

// Register write channel.
interface bsoc_cfg_if import bsoc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bsoc_mul.sv */
// ----------------------------------------------------------------------------
// Battery charge monitor shared multiplier
// Unsigned multiplier with a registered product, shared by the scaling,
// filter and segment steps of the sequencer.
// ----------------------------------------------------------------------------
module bsoc_mul #(
  parameter int unsigned AW = 22,
  parameter int unsigned BW = 14
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q;
  logic [AW+BW-1:0] p_d;

  // Full-width product of the selected operands.
  assign p_d = (AW+BW)'(a_i) * (AW+BW)'(b_i);

  // The product is registered and appears in the cycle after the operands are presented.
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* rtl/core/bsoc_core.sv */
// ----------------------------------------------------------------------------
// Battery charge monitor sequencer
// Scales one sample, runs the exponential filter and maps the filtered
// voltage to a charge reading, reusing one multiplier step by step.
// ----------------------------------------------------------------------------
module bsoc_core import bsoc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  input  logic                   vehicle_moving_i,
  input  cfg_t                   cfg_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output result_t                res_o
);

  localparam int unsigned STATE_W = MV_W + FRACTION_BITS;
  localparam int unsigned PROD_W  = STATE_W + MV_W;
  localparam int unsigned DIV_W   = SAMPLE_BITS + MV_W;
  localparam int unsigned PW      = STATE_W + ALPHA_W;

  localparam logic [SAMPLE_BITS-1:0] MAX_CODE   = '1;
  localparam logic [STATE_W-1:0]     FILT_RESET = STATE_W'(RESET_MV) << FRACTION_BITS;
  localparam logic [STATE_W-1:0]     FILT_MAX   = STATE_W'(FULL_SCALE_MV) << FRACTION_BITS;
  localparam logic [PW-1:0]          ROUND_UP   = PW'((1 << ALPHA_W) - 1);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SCALE     = 10'b00_0000_0010,
    S_DIV_INIT  = 10'b00_0000_0100,
    S_DIV       = 10'b00_0000_1000,
    S_FILT_DIFF = 10'b00_0001_0000,
    S_FILT_MUL  = 10'b00_0010_0000,
    S_FILT_UPD  = 10'b00_0100_0000,
    S_SEG       = 10'b00_1000_0000,
    S_SOC_MUL   = 10'b01_0000_0000,
    S_SOC_FIN   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   busy_done_q, busy_done_d;

  logic [SAMPLE_BITS-1:0] code_q, code_d;
  logic                   moving_q, moving_d;
  logic [DIV_W-1:0]       rem_q, rem_d;
  logic [MV_W-1:0]        quot_q, quot_d;
  logic [STATE_W-1:0]     diff_q, diff_d;
  logic                   down_q, down_d;
  logic [STATE_W-1:0]     filt_q, filt_d;
  logic [MV_W-1:0]        mv_q, mv_d;
  seg_t                   seg_q, seg_d;
  logic                   full_q, full_d;
  logic                   empty_q, empty_d;
  result_t                res_q, res_d;

  logic [STATE_W-1:0] mul_a;
  logic [MV_W-1:0]    mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic [MV_W-1:0]        div_hi;
  logic [SAMPLE_BITS-1:0] div_lo;
  logic [STATE_W-1:0]     target;
  logic [PW-1:0]          filt_p;
  logic [PW-1:0]          filt_p_up;
  logic [SOC_W-1:0]       seg_off;
  logic [SOC_W-1:0]       soc;
  level_e                 level;

  // Shared multiplier.
  bsoc_mul #(
    .AW (STATE_W),
    .BW (MV_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Operand selection for the multiplier, one use per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SCALE: begin
        mul_a = STATE_W'(code_q);
        mul_b = MV_W'(FULL_SCALE_MV);
      end
      S_FILT_MUL: begin
        mul_a = diff_q;
        mul_b = MV_W'(cfg_i.alpha);
      end
      S_SOC_MUL: begin
        mul_a = STATE_W'(mv_q - seg_q.lo);
        mul_b = MV_W'(seg_q.k);
      end
      default: ;
    endcase
  end

  // Division by the full-scale code 2^n-1: fold the high part back onto the
  // low part until the remainder fits in n bits.
  assign div_hi = rem_q[DIV_W-1:SAMPLE_BITS];
  assign div_lo = rem_q[SAMPLE_BITS-1:0];

  assign target    = {quot_q, {FRACTION_BITS{1'b0}}};
  assign filt_p    = mul_p[PW-1:0];
  assign filt_p_up = filt_p + ROUND_UP;
  assign seg_off   = mul_p[SOC_W+1:2];

  // Charge value with both clamps and the level decision.
  always_comb begin
    if (full_q) begin
      soc = SOC_W'(SOC_MAX);
    end else if (empty_q) begin
      soc = '0;
    end else begin
      soc = seg_q.base + seg_off;
    end
    if (soc <= cfg_i.crit_thr) begin
      level = LEVEL_CRITICAL;
    end else if (soc <= cfg_i.low_thr) begin
      level = LEVEL_LOW;
    end else begin
      level = LEVEL_NORMAL;
    end
  end

  // Sequencer and datapath updates.
  always_comb begin
    state_d     = state_q;
    busy_done_d = busy_done_q;
    code_d      = code_q;
    moving_d    = moving_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    diff_d      = diff_q;
    down_d      = down_q;
    filt_d      = filt_q;
    mv_d        = mv_q;
    seg_d       = seg_q;
    full_d      = full_q;
    empty_d     = empty_q;
    res_d       = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (busy_done_q) begin
          if (res_ready_i) begin
            busy_done_d = 1'b0;
          end
        end else if (in_valid_i) begin
          code_d   = adc_sample_i;
          moving_d = vehicle_moving_i;
          state_d  = S_SCALE;
        end
      end
      S_SCALE: begin
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        rem_d   = mul_p[DIV_W-1:0];
        quot_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_hi != '0) begin
          quot_d = quot_q + div_hi;
          rem_d  = DIV_W'(div_hi) + DIV_W'(div_lo);
        end else begin
          if (div_lo == MAX_CODE) begin
            quot_d = quot_q + MV_W'(1);
          end
          state_d = S_FILT_DIFF;
        end
      end
      S_FILT_DIFF: begin
        if (target >= filt_q) begin
          diff_d = target - filt_q;
          down_d = 1'b0;
        end else begin
          diff_d = filt_q - target;
          down_d = 1'b1;
        end
        state_d = S_FILT_MUL;
      end
      S_FILT_MUL: begin
        state_d = S_FILT_UPD;
      end
      S_FILT_UPD: begin
        // A falling step rounds toward minus infinity.
        if (down_q) begin
          filt_d = filt_q - STATE_W'(filt_p_up >> ALPHA_W);
        end else begin
          filt_d = filt_q + STATE_W'(filt_p >> ALPHA_W);
        end
        state_d = S_SEG;
      end
      S_SEG: begin
        mv_d    = filt_q[STATE_W-1:FRACTION_BITS];
        seg_d   = seg_of(filt_q[STATE_W-1:FRACTION_BITS]);
        full_d  = filt_q[STATE_W-1:FRACTION_BITS] >= MV_W'(MV_FULL);
        empty_d = filt_q[STATE_W-1:FRACTION_BITS] <= MV_W'(MV_EMPTY);
        state_d = S_SOC_MUL;
      end
      S_SOC_MUL: begin
        state_d = S_SOC_FIN;
      end
      S_SOC_FIN: begin
        res_d.mv    = mv_q;
        res_d.soc   = soc;
        res_d.level = level;
        res_d.stop  = (level == LEVEL_CRITICAL) && moving_q;
        busy_done_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_done_q <= 1'b0;
      filt_q      <= FILT_RESET;
    end else begin
      state_q     <= state_d;
      busy_done_q <= busy_done_d;
      filt_q      <= filt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    moving_q <= moving_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    diff_q   <= diff_d;
    down_q   <= down_d;
    mv_q     <= mv_d;
    seg_q    <= seg_d;
    full_q   <= full_d;
    empty_q  <= empty_d;
    res_q    <= res_d;
  end

  // A new sample is taken only when no finished result is waiting here.
  assign in_ready_o  = (state_q == S_IDLE) && !busy_done_q;
  assign res_valid_o = (state_q == S_IDLE) && busy_done_q;
  assign res_o       = res_q;

  // The filter never leaves the converter's full-scale range.
  a_filt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_q <= FILT_MAX)
    else $error("filter state above full scale");

  // Every folding step of the division shrinks the remainder.
  a_div_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_hi != '0) |=> (rem_q < $past(rem_q)))
    else $error("division remainder did not shrink");

  // The scaled sample never exceeds full scale.
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILT_DIFF) |-> (quot_q <= MV_W'(FULL_SCALE_MV)))
    else $error("scaled sample above full scale");

  // After a sample transfer the sequencer is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sample taken while busy");

  // A delivered charge is never above one hundred percent.
  a_soc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_q.soc <= SOC_W'(SOC_MAX)))
    else $error("charge above full");

endmodule

/* rtl/core/battery_soc_monitor_top.sv */
// ----------------------------------------------------------------------------
// Battery charge monitor
// Voltage based state of charge gauge with a filtered voltage, a charge
// reading in tenths of a percent, a level and a stop request.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one result transfer. A sample is worked
// on by a small sequencer that reuses one multiplier for the scaling, the
// filter step and the segment slope; the scaling divides by the full-scale
// code through a folding loop. The next sample is taken only once the
// sequencer has handed its finished result to the output register. The
// finished result sits in an output register, so the next sample is
// accepted while the previous result still waits; a second finished result
// holds the sequencer until the first one is taken. The register channel
// is always ready; write it only while no sample is in flight.
module battery_soc_monitor_top import bsoc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsoc_in_if.sink   in_i,
  bsoc_out_if.source out_o,
  bsoc_cfg_if.sink  cfg_i
);

  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic [THR_W-1:0]   low_q, low_d;
  logic [THR_W-1:0]   crit_q, crit_d;
  cfg_t               cfg;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // Register writes; indexes beyond the list are ignored.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    alpha_d = alpha_q;
    low_d   = low_q;
    crit_d  = crit_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ALPHA: alpha_d = cfg_i.data[ALPHA_W-1:0];
        CFG_LOW:   low_d   = cfg_i.data[THR_W-1:0];
        CFG_CRIT:  crit_d  = cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_W'(ALPHA_RESET);
      low_q   <= THR_W'(LOW_RESET);
      crit_q  <= THR_W'(CRIT_RESET);
    end else begin
      alpha_q <= alpha_d;
      low_q   <= low_d;
      crit_q  <= crit_d;
    end
  end

  assign cfg.alpha    = alpha_q;
  assign cfg.low_thr  = low_q;
  assign cfg.crit_thr = crit_q;

  // Sequencer.
  bsoc_core #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .adc_sample_i     (in_i.adc_sample[SAMPLE_BITS-1:0]),
    .vehicle_moving_i (in_i.vehicle_moving),
    .cfg_i            (cfg),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  // Output register: loads when empty or when its result is being taken.
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.filtered_millivolts = out_q.mv;
  assign out_o.charge_tenths       = out_q.soc;
  assign out_o.charge_level        = out_q.level;
  assign out_o.stop_request        = out_q.stop;

endmodule

/* sim/soc_reading_checker.sv */
// ----------------------------------------------------------------------------
// Battery charge reading checker
// Watches the sample, reading and register channels of the battery charge
// monitor, predicts every reading from its own copy of the filter and the
// registers, and compares each reading transfer field by field.
// ----------------------------------------------------------------------------
module soc_reading_checker import bsoc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sample channel.
  input  logic                   smp_valid_i,
  input  logic                   smp_ready_i,
  input  logic [SAMPLE_BITS-1:0] smp_code_i,
  input  logic                   smp_moving_i,
  // Reading channel.
  input  logic                   rd_valid_i,
  input  logic                   rd_ready_i,
  input  logic [MV_W-1:0]        rd_mv_i,
  input  logic [SOC_W-1:0]       rd_soc_i,
  input  logic [LEVEL_W-1:0]     rd_level_i,
  input  logic                   rd_stop_i,
  // Register write channel.
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Progress and error counts for the testbench top.
  output int unsigned            results_seen_o,
  output int unsigned            mismatches_o
);

  localparam int unsigned ACC_W       = MV_W + FRACTION_BITS;
  localparam int unsigned PRINT_LIMIT = 40;

  // Shadow copy of the registers and the filter accumulator.
  logic [ALPHA_W-1:0] alpha_q;
  logic [THR_W-1:0]   low_thr_q;
  logic [THR_W-1:0]   crit_thr_q;
  logic [ACC_W-1:0]   filter_acc;

  // Readings predicted for accepted samples, oldest first.
  result_t            pending_readings[$];
  result_t            want;
  int unsigned        mismatch_total;

  assign mismatches_o = mismatch_total;

  // Print one line per mismatch (up to a limit) and count it.
  task automatic flag_mismatch(input string what);
    if (mismatch_total < PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    mismatch_total++;
  endtask

  // Piecewise linear charge in tenths of a percent, truncated toward zero.
  function automatic logic [SOC_W-1:0] charge_from_mv(input logic [MV_W-1:0] mv);
    int unsigned v;
    int unsigned soc;
    v = mv;
    if (v >= MV_FULL) begin
      soc = SOC_MAX;
    end else if (v <= MV_EMPTY) begin
      soc = 0;
    end else if (v >= 8000) begin
      soc = 900 + (v - 8000) / 4;
    end else if (v >= 7600) begin
      soc = 700 + (v - 7600) / 2;
    end else if (v >= 7200) begin
      soc = 400 + ((v - 7200) * 3) / 4;
    end else if (v >= 6800) begin
      soc = 200 + (v - 6800) / 2;
    end else if (v >= 6400) begin
      soc = 100 + (v - 6400) / 4;
    end else begin
      soc = (v - MV_EMPTY) / 4;
    end
    if (soc > SOC_MAX) begin
      soc = SOC_MAX;
    end
    return SOC_W'(soc);
  endfunction

  // Scale a sample, step the filter and derive the full reading.
  function automatic result_t predict_reading(input logic [SAMPLE_BITS-1:0] code,
                                              input logic moving);
    longint unsigned full_code;
    longint unsigned sample_mv;
    longint unsigned target;
    longint unsigned delta;
    longint unsigned nudge;
    longint unsigned acc;
    result_t         r;
    full_code = (longint'(1) << SAMPLE_BITS) - 1;
    sample_mv = (longint'(code) * FULL_SCALE_MV) / full_code;
    target    = sample_mv << FRACTION_BITS;
    acc       = filter_acc;
    // The filter step is floored, so a falling step rounds away from zero.
    if (target >= acc) begin
      delta = target - acc;
      nudge = (longint'(alpha_q) * delta) >> ALPHA_W;
      acc   = acc + nudge;
    end else begin
      delta = acc - target;
      nudge = (longint'(alpha_q) * delta + 255) >> ALPHA_W;
      acc   = acc - nudge;
    end
    filter_acc = ACC_W'(acc);
    r.mv  = MV_W'(acc >> FRACTION_BITS);
    r.soc = charge_from_mv(r.mv);
    // Critical wins over low when both thresholds are met.
    if (r.soc <= crit_thr_q) begin
      r.level = LEVEL_CRITICAL;
    end else if (r.soc <= low_thr_q) begin
      r.level = LEVEL_LOW;
    end else begin
      r.level = LEVEL_NORMAL;
    end
    r.stop = (r.level == LEVEL_CRITICAL) && moving;
    return r;
  endfunction

  // Follow every transfer: readings first, then samples, then register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q        = ALPHA_W'(ALPHA_RESET);
      low_thr_q      = THR_W'(LOW_RESET);
      crit_thr_q     = THR_W'(CRIT_RESET);
      filter_acc     = ACC_W'(RESET_MV) << FRACTION_BITS;
      pending_readings.delete();
      mismatch_total = 0;
      results_seen_o <= 0;
    end else begin
      if (rd_valid_i && rd_ready_i) begin
        if (pending_readings.size() == 0) begin
          flag_mismatch("reading transfer with no sample outstanding");
        end else begin
          want = pending_readings.pop_front();
          if (rd_mv_i !== want.mv) begin
            flag_mismatch($sformatf("filtered_millivolts got %0d want %0d", rd_mv_i, want.mv));
          end
          if (rd_soc_i !== want.soc) begin
            flag_mismatch($sformatf("charge_tenths got %0d want %0d", rd_soc_i, want.soc));
          end
          if (rd_level_i !== want.level) begin
            flag_mismatch($sformatf("charge_level got %0d want %0d", rd_level_i, want.level));
          end
          if (rd_stop_i !== want.stop) begin
            flag_mismatch($sformatf("stop_request got %0b want %0b", rd_stop_i, want.stop));
          end
        end
        results_seen_o <= results_seen_o + 1;
      end
      if (smp_valid_i && smp_ready_i) begin
        pending_readings.push_back(predict_reading(smp_code_i, smp_moving_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ALPHA: alpha_q    = cfg_data_i[ALPHA_W-1:0];
          CFG_LOW:   low_thr_q  = cfg_data_i[THR_W-1:0];
          CFG_CRIT:  crit_thr_q = cfg_data_i[THR_W-1:0];
          default:   ;
        endcase
      end
    end
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Battery charge monitor testbench
// Drives samples and register writes into the monitor with random pacing on
// both channels, holds off readings for long stretches to back up the input,
// and leaves prediction and comparison to the reading checker.
// ----------------------------------------------------------------------------
module tb;
  import bsoc_pkg::*;

  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned IDLE_MAX      = 17;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RUN_CYCLES    = 600000;
  localparam int unsigned PHASE_ITEMS   = 135;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          sender_paced;
  int unsigned samples_sent;
  int unsigned settings_used;
  int unsigned results_seen;
  int unsigned mismatches;

  bsoc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
  bsoc_out_if rd_if ();
  bsoc_cfg_if cfg_if ();

  battery_soc_monitor_top #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (smp_if),
    .out_o (rd_if),
    .cfg_i (cfg_if)
  );

  soc_reading_checker #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .smp_valid_i   (smp_if.valid),
    .smp_ready_i   (smp_if.ready),
    .smp_code_i    (smp_if.adc_sample),
    .smp_moving_i  (smp_if.vehicle_moving),
    .rd_valid_i    (rd_if.valid),
    .rd_ready_i    (rd_if.ready),
    .rd_mv_i       (rd_if.filtered_millivolts),
    .rd_soc_i      (rd_if.charge_tenths),
    .rd_level_i    (rd_if.charge_level),
    .rd_stop_i     (rd_if.stop_request),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_index_i   (cfg_if.index),
    .cfg_data_i    (cfg_if.data),
    .results_seen_o(results_seen),
    .mismatches_o  (mismatches)
  );

  // Free-running clock.
  always #(CLK_HALF) clk_i = ~clk_i;

  // Hard stop in case the run hangs.
  initial begin
    #(2 * CLK_HALF * RUN_CYCLES);
    $display("battery_soc_monitor_top verification failed");
    $finish;
  end

  // Reading sink: random stalls, stretches without stalls, and two long holds
  // that let the monitor fill up and stall its sample input.
  initial begin : reading_sink
    int unsigned wait_cycles;
    int unsigned taken;
    taken = 0;
    rd_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken == 180 || taken == 760) begin
        wait_cycles = HOLD_CYCLES;
      end else if ((taken / 60) % 3 == 1) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, IDLE_MAX);
      end
      if (wait_cycles > 0) begin
        rd_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      rd_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rd_if.valid);
      taken++;
    end
  end

  // Offer one sample after an optional gap; valid stays high afterwards so a
  // back-to-back sample needs no extra edge.
  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] code, input logic moving);
    int unsigned gap;
    gap = sender_paced ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid          <= 1'b1;
    smp_if.adc_sample     <= code;
    smp_if.vehicle_moving <= moving;
    do @(posedge clk_i); while (!smp_if.ready);
    samples_sent++;
  endtask

  // Stop offering and wait until every sample has produced its reading.
  task automatic drain_readings();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen != samples_sent);
  endtask

  // One register transfer; valid is left high for the next write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Reprogram all registers while the monitor is idle.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] alpha_word,
                                input logic [CFG_DATA_W-1:0] low_thr,
                                input logic [CFG_DATA_W-1:0] crit_thr,
                                input bit with_spare);
    drain_readings();
    write_register(CFG_ALPHA, alpha_word);
    write_register(CFG_LOW, low_thr);
    write_register(CFG_CRIT, crit_thr);
    if (with_spare) begin
      write_register(CFG_SPARE, CFG_DATA_W'($urandom));
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly slow sweeps through the battery range with jitter, plus full-range
  // noise and rail codes; the motion flag changes in runs.
  task automatic run_random_phase(input int unsigned count);
    int          level_code;
    int          dir;
    int          jitter;
    int unsigned pick;
    logic        moving;
    logic [SAMPLE_BITS-1:0] code;
    level_code = $urandom_range(2300, 3500);
    dir        = ($urandom_range(0, 1) == 1) ? 1 : -1;
    moving     = 1'($urandom_range(0, 1));
    for (int unsigned n = 0; n < count; n++) begin
      sender_paced = ((n / 40) % 3) != 2;
      if ($urandom_range(0, 15) == 0) begin
        moving = ~moving;
      end
      level_code = level_code + dir * int'($urandom_range(0, 24));
      if (level_code > 3700) begin
        level_code = 3700;
        dir        = -1;
      end else if (level_code < 2200) begin
        level_code = 2200;
        dir        = 1;
      end else if ($urandom_range(0, 19) == 0) begin
        dir = -dir;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        jitter = int'($urandom_range(0, 30)) - 15;
        code   = SAMPLE_BITS'(level_code + jitter);
      end else if (pick < 90) begin
        code = SAMPLE_BITS'($urandom);
      end else begin
        code = pick[0] ? {SAMPLE_BITS{1'b1}} : '0;
      end
      offer_sample(code, moving);
    end
  endtask

  // Main stimulus and verdict.
  initial begin : stimulus
    int unsigned waited;
    smp_if.valid          <= 1'b0;
    smp_if.adc_sample     <= '0;
    smp_if.vehicle_moving <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= CFG_ALPHA;
    cfg_if.data           <= '0;
    samples_sent  = 0;
    settings_used = 0;
    sender_paced  = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a few samples on the reset settings.
    offer_sample(12'hFFF, 1'b1);
    offer_sample(12'h000, 1'b0);
    offer_sample(12'h800, 1'b1);

    // Directed: fastest filter, rails, alternating bits and segment edges.
    apply_settings(10'd255, 10'd200, 10'd100, 1'b1);
    offer_sample(12'h000, 1'b1);
    offer_sample(12'h000, 1'b1);
    offer_sample(12'h000, 1'b0);
    offer_sample(12'hFFF, 1'b0);
    offer_sample(12'hFFF, 1'b1);
    offer_sample(12'hAAA, 1'b1);
    offer_sample(12'h555, 1'b0);
    offer_sample(12'd2482, 1'b1);
    offer_sample(12'd2482, 1'b1);
    offer_sample(12'd2648, 1'b1);
    offer_sample(12'd2647, 1'b1);
    offer_sample(12'd2813, 1'b0);
    offer_sample(12'd2813, 1'b0);
    offer_sample(12'd2979, 1'b1);
    offer_sample(12'd2979, 1'b1);
    offer_sample(12'd3144, 1'b0);
    offer_sample(12'd3144, 1'b0);
    offer_sample(12'd3309, 1'b1);
    offer_sample(12'd3309, 1'b1);
    offer_sample(12'd3475, 1'b0);
    offer_sample(12'd3475, 1'b0);

    // Random phases over a spread of settings, extremes included.
    apply_settings(10'd26, 10'd200, 10'd100, 1'b1);
    run_random_phase(PHASE_ITEMS);
    apply_settings(10'd1, 10'd1023, 10'd0, 1'b0);
    run_random_phase(PHASE_ITEMS);
    // Critical threshold above the low threshold.
    apply_settings(10'd255, 10'd0, 10'd1023, 1'b1);
    run_random_phase(PHASE_ITEMS);
    // Alpha word whose low byte is zero: the filter must hold.
    apply_settings(10'h100, 10'd500, 10'd300, 1'b0);
    run_random_phase(60);
    apply_settings(10'h3FF, 10'd1000, 10'd1000, 1'b0);
    run_random_phase(PHASE_ITEMS);
    for (int unsigned p = 0; p < 3; p++) begin
      apply_settings({2'($urandom), 8'($urandom_range(1, 255))},
                     10'($urandom), 10'($urandom), 1'($urandom_range(0, 1)));
      run_random_phase(PHASE_ITEMS);
    end
    apply_settings(10'd128, 10'd300, 10'd150, 1'b1);
    run_random_phase(PHASE_ITEMS);
    smp_if.valid <= 1'b0;

    // Wait for the last readings, then watch for strays.
    waited = 0;
    while (results_seen != samples_sent && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d samples and %0d readings over %0d register settings,",
             samples_sent, results_seen, settings_used);
    $display("including a held filter, crossed thresholds and long reading holds.");
    if (mismatches == 0 && results_seen == samples_sent) begin
      $display("battery_soc_monitor_top verification clean");
    end else begin
      $display("battery_soc_monitor_top verification failed");
    end
    $finish;
  end

endmodule
